>>> design/kop_pkg.sv
// Shared types and constants for the two-season climate classifier.
// No dependencies; imported by every module of the block.
package kop_pkg;

  localparam int RainBits = 12;
  localparam int TempBits = 8;
  localparam int AnnBits  = 16;  // annual rain, at most 12 * 4095
  localparam int CodeBits = 5;

  // Input item as it moves through the pipeline
  typedef struct packed {
    logic [RainBits-1:0] winter_rain;
    logic [RainBits-1:0] summer_rain;
    logic [TempBits-1:0] min_temp;
    logic [TempBits-1:0] max_temp;
  } kop_item_t;

  typedef struct packed {
    kop_item_t          item;
    logic [AnnBits-1:0] annual_rain;
  } kop_stage_t;

  typedef enum logic [1:0] {
    RainLetS = 2'd0,
    RainLetW = 2'd1,
    RainLetF = 2'd2
  } kop_rain_e;

  typedef enum logic [1:0] {
    HeatLetA = 2'd0,
    HeatLetB = 2'd1,
    HeatLetC = 2'd2,
    HeatLetD = 2'd3
  } kop_heat_e;

  // Class codes
  localparam logic [CodeBits-1:0] CodeAf    = 5'd1;
  localparam logic [CodeBits-1:0] CodeAm    = 5'd2;
  localparam logic [CodeBits-1:0] CodeAw    = 5'd3;
  localparam logic [CodeBits-1:0] CodeAs    = 5'd4;
  localparam logic [CodeBits-1:0] CodeBWh   = 5'd5;
  localparam logic [CodeBits-1:0] CodeBWk   = 5'd6;
  localparam logic [CodeBits-1:0] CodeBSh   = 5'd7;
  localparam logic [CodeBits-1:0] CodeBSk   = 5'd8;
  localparam logic [CodeBits-1:0] CodeCBase = 5'd9;
  localparam logic [CodeBits-1:0] CodeDBase = 5'd18;
  localparam logic [CodeBits-1:0] CodeET    = 5'd30;
  localparam logic [CodeBits-1:0] CodeEF    = 5'd31;

  // Season weighting
  localparam logic [3:0] MonthsYear   = 4'd12;
  localparam logic [3:0] SummerMinMon = 4'd4;
  localparam int         SummerMaxMon = 11;

  // Dryness threshold boosts
  localparam logic signed [13:0] BoostHigh = 14'sd280;
  localparam logic signed [13:0] BoostLow  = 14'sd140;

endpackage

>>> design/kop_rain.sv
// Annual rain from the two seasonal rainfalls, with the summer month ladder.
// Depends on kop_pkg.
module kop_rain
  import kop_pkg::*;
(
  input  kop_item_t          item_i,
  output logic [AnnBits-1:0] annual_rain_o
);

  logic [AnnBits-1:0] winter12;
  logic [AnnBits-1:0] ms;
  logic [3:0]         sf;

  always_comb begin
    winter12 = AnnBits'(item_i.winter_rain) * AnnBits'(MonthsYear);
    sf       = SummerMinMon;
    ms       = '0;
    // sf = min(11, max(4, floor(12w/s))); the ladder is monotone, so the last hit wins
    for (int m = 5; m <= SummerMaxMon; m++) begin
      ms = AnnBits'(m) * AnnBits'(item_i.summer_rain);
      if (winter12 >= ms) begin
        sf = 4'(m);
      end
    end
    if (item_i.summer_rain > item_i.winter_rain) begin
      annual_rain_o = AnnBits'(item_i.winter_rain) * AnnBits'(MonthsYear - sf)
                    + AnnBits'(item_i.summer_rain) * AnnBits'(sf);
    end else begin
      annual_rain_o = AnnBits'(6) * (AnnBits'(item_i.winter_rain)
                    + AnnBits'(item_i.summer_rain));
    end
  end

endmodule

>>> design/kop_class.sv
// Group, rain letter and heat letter selection into the final class code.
// Depends on kop_pkg; takes annual rain from kop_rain via the stage register.
module kop_class
  import kop_pkg::*;
(
  input  kop_stage_t          stage_i,
  output logic [CodeBits-1:0] climate_code_o
);

  logic [RainBits-1:0]        w, s, minr;
  logic [AnnBits-1:0]         r;
  logic signed [TempBits-1:0] lo, hi;
  logic signed [8:0]          tsum;
  logic signed [13:0]         p;
  logic [18:0]                s60, r7, r3;
  logic signed [18:0]         r2_s, r_s, p_s;
  logic [17:0]                mon_idx;
  logic [15:0]                w10;
  logic [13:0]                s3;
  logic                       hot;
  kop_rain_e                  rain_let;
  kop_heat_e                  heat_let;
  logic [CodeBits-1:0]        rain_idx, heat_idx;

  always_comb begin
    w    = stage_i.item.winter_rain;
    s    = stage_i.item.summer_rain;
    lo   = $signed(stage_i.item.min_temp);
    hi   = $signed(stage_i.item.max_temp);
    r    = stage_i.annual_rain;
    minr = (w < s) ? w : s;
    tsum = 9'(lo) + 9'(hi);
    hot  = (tsum >= 9'sd36);

    // Dryness threshold; 0.7 and 0.3 summer fractions by cross-multiplication
    s60 = 19'(s) * 19'd60;
    r7  = 19'(r) * 19'd7;
    r3  = 19'(r) * 19'd3;
    p   = 14'(tsum) * 14'sd10;
    if (r != '0) begin
      if (s60 >= r7) begin
        p = p + BoostHigh;
      end else if (s60 >= r3) begin
        p = p + BoostLow;
      end
    end
    r_s  = $signed({3'b000, r});
    r2_s = r_s <<< 1;
    p_s  = 19'(p);

    mon_idx = 18'(minr) * 18'd25 + 18'(r);
    s3      = 14'(s) * 14'd3;
    w10     = 16'(w) * 16'd10;

    if ((s3 < 14'(w)) && (s < 12'd40)) begin
      rain_let = RainLetS;
    end else if (w10 < 16'(s)) begin
      rain_let = RainLetW;
    end else begin
      rain_let = RainLetF;
    end

    if (hi >= 8'sd22) begin
      heat_let = HeatLetA;
    end else if (hi >= 8'sd14) begin
      heat_let = HeatLetB;
    end else if (lo <= -8'sd38) begin
      heat_let = HeatLetD;
    end else begin
      heat_let = HeatLetC;
    end

    case (rain_let)
      RainLetS: rain_idx = 5'd0;
      RainLetW: rain_idx = 5'd1;
      RainLetF: rain_idx = 5'd2;
      default:  rain_idx = 5'd2;
    endcase
    heat_idx = 5'(heat_let);

    if (hi <= 8'sd10) begin
      climate_code_o = (hi >= 8'sd0) ? CodeET : CodeEF;
    end else if (r2_s < p_s) begin
      climate_code_o = hot ? CodeBWh : CodeBWk;
    end else if (r_s <= p_s) begin
      climate_code_o = hot ? CodeBSh : CodeBSk;
    end else if (lo >= 8'sd18) begin
      if (minr >= 12'd60) begin
        climate_code_o = CodeAf;
      end else if (mon_idx >= 18'd2500) begin
        climate_code_o = CodeAm;
      end else if (s < 12'd60) begin
        climate_code_o = CodeAs;
      end else begin
        climate_code_o = CodeAw;
      end
    end else if (lo > -8'sd3) begin
      // C never reaches heat letter d; clamp anyway
      if (heat_let == HeatLetD) begin
        heat_idx = 5'(HeatLetC);
      end
      climate_code_o = CodeCBase + rain_idx * 5'd3 + heat_idx;
    end else begin
      climate_code_o = CodeDBase + (rain_idx << 2) + heat_idx;
    end
  end

endmodule

>>> design/koppen_two_season_classifier.sv
// Two-season climate classifier, top level. Depends on kop_pkg, kop_rain, kop_class.
// Result strobe done_o follows the accepting edge through the valid chain in_vld_q, s1_vld_q, done_q.
// Throughput: one item per cycle; busy_o is always low, the pipeline never stalls.
// Stages: input register, annual rain register, result register.
// Reset clears the stage valid bits only; the receiver cannot stall results.
module koppen_two_season_classifier
  import kop_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [RainBits-1:0] winter_rain_i,
  input  logic [RainBits-1:0] summer_rain_i,
  input  logic [TempBits-1:0] min_temp_i,
  input  logic [TempBits-1:0] max_temp_i,
  output logic                done_o,
  output logic [CodeBits-1:0] climate_code_o
);

  logic                in_vld_q, s1_vld_q, done_q;
  kop_item_t           in_q;
  kop_stage_t          s1_d, s1_q;
  logic [AnnBits-1:0]  annual_rain;
  logic [CodeBits-1:0] code_d, code_q;

  assign busy_o = 1'b0;

  kop_rain u_rain (
    .item_i        (in_q),
    .annual_rain_o (annual_rain)
  );

  assign s1_d = '{item: in_q, annual_rain: annual_rain};

  kop_class u_class (
    .stage_i        (s1_q),
    .climate_code_o (code_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
      s1_vld_q <= in_vld_q;
      done_q   <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= '{winter_rain: winter_rain_i, summer_rain: summer_rain_i,
                min_temp: min_temp_i, max_temp: max_temp_i};
    end
    s1_q   <= s1_d;
    code_q <= code_d;
  end

  assign done_o         = done_q;
  assign climate_code_o = code_q;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 done_o)
    else $error("accepted item produced no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##3 !done_o)
    else $error("result without an accepted item");

  a_code_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (climate_code_o != '0))
    else $error("class code out of range");

  a_stage_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |=> done_q)
    else $error("stage valid lost between annual rain and result");

endmodule

>>> tb/sv/koppen_two_season_classifier_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for koppen_two_season_classifier: directed and random cells,
// with an in-bench climate code predictor and an ordered scoreboard. Depends on kop_pkg.
module koppen_two_season_classifier_test;
  import kop_pkg::*;

  localparam int CycleLimit = 200000;

  // Holds predicted codes in item order and compares each strobed result against them
  class climate_code_board;
    logic [CodeBits-1:0] pending_codes[$];
    int                  errors;
    int                  cells_seen;
    int                  codes_checked;
    bit                  class_hit[32];

    function automatic logic [CodeBits-1:0] koppen_code(logic [RainBits-1:0] w_b,
                                                        logic [RainBits-1:0] s_b,
                                                        logic signed [TempBits-1:0] lo_b,
                                                        logic signed [TempBits-1:0] hi_b);
      int        w, s, lo, hi, ann, months, thr, min_r, m;
      kop_rain_e rain_let;
      kop_heat_e heat_let;
      w = w_b;
      s = s_b;
      lo = lo_b;
      hi = hi_b;
      min_r = (w < s) ? w : s;
      if (s > w) begin
        // summer length from the ratio ladder, never below four months
        months = 4;
        for (m = 5; m <= 11; m++) begin
          if (12 * w >= m * s) months = m;
        end
        ann = w * (12 - months) + s * months;
      end else begin
        ann = 6 * (w + s);
      end
      if (hi <= 10) return (hi >= 0) ? CodeET : CodeEF;
      thr = 10 * (lo + hi);
      if (ann > 0) begin
        if (60 * s >= 7 * ann) thr += 280;
        else if (60 * s >= 3 * ann) thr += 140;
      end
      if (2 * ann < thr) return (lo + hi >= 36) ? CodeBWh : CodeBWk;
      if (ann <= thr) return (lo + hi >= 36) ? CodeBSh : CodeBSk;
      if (lo >= 18) begin
        if (min_r >= 60) return CodeAf;
        if (25 * min_r + ann >= 2500) return CodeAm;
        if (s < 60) return CodeAs;
        return CodeAw;
      end
      if (3 * s < w && s < 40) rain_let = RainLetS;
      else if (10 * w < s) rain_let = RainLetW;
      else rain_let = RainLetF;
      if (hi >= 22) heat_let = HeatLetA;
      else if (hi >= 14) heat_let = HeatLetB;
      else if (lo <= -38) heat_let = HeatLetD;
      else heat_let = HeatLetC;
      if (lo > -3) begin
        if (heat_let == HeatLetD) heat_let = HeatLetC;
        return CodeBits'(CodeCBase + 3 * rain_let + heat_let);
      end
      return CodeBits'(CodeDBase + 4 * rain_let + heat_let);
    endfunction

    function void note_cell(logic [RainBits-1:0] w, logic [RainBits-1:0] s,
                            logic [TempBits-1:0] lo, logic [TempBits-1:0] hi);
      pending_codes.push_back(koppen_code(w, s, lo, hi));
      cells_seen++;
    endfunction

    function void check_code(logic [CodeBits-1:0] got);
      logic [CodeBits-1:0] want;
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected result, climate_code got %0d", $time, got);
        errors++;
        return;
      end
      want = pending_codes.pop_front();
      codes_checked++;
      if (got !== want) begin
        $display("%0t: climate_code mismatch, expected %0d got %0d", $time, want, got);
        errors++;
      end else begin
        class_hit[want] = 1'b1;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [RainBits-1:0] winter_rain_i;
  logic [RainBits-1:0] summer_rain_i;
  logic [TempBits-1:0] min_temp_i;
  logic [TempBits-1:0] max_temp_i;
  logic                done_o;
  logic [CodeBits-1:0] climate_code_o;

  climate_code_board board = new();
  int                idle_pct;
  int                cycle_count;

  koppen_two_season_classifier DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .winter_rain_i  (winter_rain_i),
    .summer_rain_i  (summer_rain_i),
    .min_temp_i     (min_temp_i),
    .max_temp_i     (max_temp_i),
    .done_o         (done_o),
    .climate_code_o (climate_code_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Accepted items and strobed results, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) board.note_cell(winter_rain_i, summer_rain_i, min_temp_i,
                                              max_temp_i);
      if (done_o) board.check_code(climate_code_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               board.pending_codes.size());
      $display("koppen_two_season_classifier_test: FAIL");
      $finish;
    end
  end

  // One item; random idle cycles before it carry junk fields with start low
  task automatic send_cell(input logic [RainBits-1:0] w, input logic [RainBits-1:0] s,
                           input logic [TempBits-1:0] lo, input logic [TempBits-1:0] hi);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i       <= 1'b0;
      winter_rain_i <= $urandom;
      summer_rain_i <= $urandom;
      min_temp_i    <= $urandom;
      max_temp_i    <= $urandom;
      @(negedge clk_i);
    end
    start_i       <= 1'b1;
    winter_rain_i <= w;
    summer_rain_i <= s;
    min_temp_i    <= lo;
    max_temp_i    <= hi;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Mostly plausible climates so every group is reached; one in ten is raw noise
  task automatic random_cell;
    int pick, w, s, lo, hi;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      w  = $urandom_range(0, 4095);
      s  = $urandom_range(0, 4095);
      lo = $urandom_range(0, 255);
      hi = $urandom_range(0, 255);
    end else begin
      w  = $urandom_range(0, (pick < 6) ? 300 : 2500);
      s  = $urandom_range(0, (pick < 4) ? 60 : 400);
      if (pick == 9) w = $urandom_range(0, 20);
      hi = $urandom_range(0, 50) - 8;
      lo = hi - $urandom_range(0, 55);
      if ($urandom_range(0, 19) == 0) lo = hi + $urandom_range(1, 10);
      if (lo < -128) lo = -128;
      if (lo > 127) lo = 127;
    end
    send_cell(w[RainBits-1:0], s[RainBits-1:0], lo[TempBits-1:0], hi[TempBits-1:0]);
  endtask

  initial begin
    int n, phase;
    int phase_idle[4];
    phase_idle    = '{0, 47, 0, 38};
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    winter_rain_i = '0;
    summer_rain_i = '0;
    min_temp_i    = '0;
    max_temp_i    = '0;
    idle_pct      = 0;
    cycle_count   = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, zero rain, E/B/A/C/D letters, min above max
    send_cell(12'd0, 12'd0, 8'sd20, 8'sd30);
    send_cell(12'd4095, 12'd4095, 8'sd127, 8'sd127);
    send_cell(12'd0, 12'd4095, -8'sd128, 8'sd127);
    send_cell(12'd4095, 12'd0, -8'sd128, -8'sd128);
    send_cell(12'd100, 12'd100, 8'sd5, 8'sd10);
    send_cell(12'd100, 12'd100, 8'sd5, 8'sd0);
    send_cell(12'd100, 12'd100, 8'sd5, -8'sd1);
    send_cell(12'd200, 12'd200, 8'sd20, 8'sd30);
    send_cell(12'd30, 12'd300, 8'sd20, 8'sd30);
    send_cell(12'd300, 12'd40, 8'sd20, 8'sd25);
    send_cell(12'd100, 12'd80, 8'sd20, 8'sd25);
    send_cell(12'd400, 12'd30, 8'sd10, 8'sd25);
    send_cell(12'd10, 12'd300, 8'sd10, 8'sd25);
    send_cell(12'd150, 12'd150, 8'sd10, 8'sd18);
    send_cell(12'd150, 12'd150, 8'sd10, 8'sd12);
    send_cell(12'd150, 12'd150, -8'sd10, 8'sd25);
    send_cell(12'd150, 12'd150, -8'sd40, 8'sd12);
    send_cell(12'd150, 12'd150, -8'sd38, 8'sd13);
    send_cell(12'd150, 12'd150, -8'sd3, 8'sd20);
    send_cell(12'd150, 12'd150, -8'sd2, 8'sd20);
    send_cell(12'd10, 12'd20, 8'sd15, 8'sd30);
    send_cell(12'd50, 12'd60, 8'sd30, 8'sd10);
    send_cell(12'd50, 12'd200, 8'sd30, 8'sd11);
    send_cell(12'd1, 12'd4095, 8'sd0, 8'sd11);
    send_cell(12'd4095, 12'd4094, -8'sd128, 8'sd11);

    for (phase = 0; phase < 4; phase++) begin
      idle_pct = phase_idle[phase];
      for (n = 0; n < 375; n++) random_cell();
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    while (board.pending_codes.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    n = 0;
    for (phase = 1; phase < 32; phase++) n += board.class_hit[phase];
    $display("Classified %0d cells, checked %0d codes, %0d of 31 climate classes hit.",
             board.cells_seen, board.codes_checked, n);
    if (board.errors == 0 && board.pending_codes.size() == 0) begin
      $display("koppen_two_season_classifier_test: PASS");
    end else begin
      $display("koppen_two_season_classifier_test: FAIL");
    end
    $finish;
  end

endmodule
